// ===== hdl/flt_pkg.sv =====
// Package of shared types and constants for the FIFO hand-off lock table.
`timescale 1ns / 1ps

package flt_pkg;

  localparam int CMD_W       = 2;
  localparam int TID_W       = 4;
  localparam int LID_W       = 6;
  localparam int STATUS_W    = 3;

  localparam int DEF_NUM_LOCKS   = 64;
  localparam int DEF_NUM_THREADS = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOCK   = 2'd0,
    CMD_TRY    = 2'd1,
    CMD_UNLOCK = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED    = 3'd0,
    ST_QUEUED     = 3'd1,
    ST_REFUSED    = 3'd2,
    ST_FREED      = 3'd3,
    ST_HANDED     = 3'd4,
    ST_NOT_OWNER  = 3'd5,
    ST_QUEUE_FULL = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_POP
  } state_t;

  typedef struct packed {
    status_t              status;
    logic [TID_W-1:0]     next_owner;
    logic                 next_owner_valid;
  } result_t;

endpackage

// ===== hdl/flt_ram.sv =====
// Single-port-write, single-port-read synchronous memory with registered read data.
`timescale 1ns / 1ps

module flt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/flt_ctrl.sv =====
// Request sequencer: clearing pass, lock entry read-modify-write and queue push/pop.
`timescale 1ns / 1ps

module flt_ctrl #(
  parameter int NUM_LOCKS   = flt_pkg::DEF_NUM_LOCKS,
  parameter int NUM_THREADS = flt_pkg::DEF_NUM_THREADS,
  parameter int LW          = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1,
  parameter int TW          = $clog2(NUM_THREADS),
  parameter int QAW         = $clog2(NUM_LOCKS * NUM_THREADS),
  parameter int ENT_W       = 2 + flt_pkg::TID_W + 2 * TW
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [flt_pkg::CMD_W-1:0]   command,
  input  logic [flt_pkg::TID_W-1:0]   requester,
  input  logic [flt_pkg::LID_W-1:0]   lock_id,
  output logic                        busy,
  output flt_pkg::result_t            res,
  output logic                        done,
  output logic                        lk_we,
  output logic [LW-1:0]               lk_waddr,
  output logic [ENT_W-1:0]            lk_wdata,
  output logic                        lk_re,
  output logic [LW-1:0]               lk_raddr,
  input  logic [ENT_W-1:0]            lk_rdata,
  output logic                        q_we,
  output logic [QAW-1:0]              q_waddr,
  output logic [flt_pkg::TID_W-1:0]   q_wdata,
  output logic                        q_re,
  output logic [QAW-1:0]              q_raddr,
  input  logic [flt_pkg::TID_W-1:0]   q_rdata
);

  localparam int CNT_W = TW + 1;
  localparam logic [QAW-1:0] NT_Q = QAW'(NUM_THREADS);

  typedef struct packed {
    logic                       held;
    logic [flt_pkg::TID_W-1:0]  owner;
    logic [TW-1:0]              head;
    logic [CNT_W-1:0]           count;
  } entry_t;

  flt_pkg::state_t            state, state_next;
  logic [LW-1:0]              clr_idx, clr_idx_next;
  logic [flt_pkg::CMD_W-1:0]  req_cmd;
  logic [flt_pkg::TID_W-1:0]  req_tid;
  logic [LW-1:0]              req_lid;
  logic                       req_bad;
  logic [TW-1:0]              pop_head, pop_head_next;
  logic [CNT_W-1:0]           pop_count, pop_count_next;
  flt_pkg::result_t           res_next;
  logic                       done_next;

  entry_t                     ent, ent_wr;
  logic [QAW-1:0]             qbase;
  logic [CNT_W-1:0]           tail_sum, head_inc;
  logic [TW-1:0]              tail_slot;

  assign ent      = entry_t'(lk_rdata);
  assign lk_wdata = ENT_W'(ent_wr);
  assign qbase    = QAW'(req_lid) * NT_Q;
  assign tail_sum = CNT_W'(ent.head) + ent.count;
  assign tail_slot = (tail_sum >= CNT_W'(NUM_THREADS)) ?
                     TW'(tail_sum - CNT_W'(NUM_THREADS)) : TW'(tail_sum);
  assign head_inc = CNT_W'(ent.head) + CNT_W'(1);
  assign busy     = (state != flt_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= flt_pkg::S_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    res       <= res_next;
    pop_head  <= pop_head_next;
    pop_count <= pop_count_next;
    if (state == flt_pkg::S_IDLE && start) begin
      req_cmd <= command;
      req_tid <= requester;
      req_lid <= LW'(lock_id);
      req_bad <= (32'(lock_id) >= 32'(NUM_LOCKS)) || (32'(requester) >= 32'(NUM_THREADS));
    end
  end

  always_comb begin
    state_next     = state;
    clr_idx_next   = clr_idx;
    done_next      = 1'b0;
    res_next       = res;
    pop_head_next  = pop_head;
    pop_count_next = pop_count;
    lk_we          = 1'b0;
    lk_waddr       = req_lid;
    ent_wr         = ent;
    lk_re          = 1'b0;
    lk_raddr       = LW'(lock_id);
    q_we           = 1'b0;
    q_waddr        = qbase + QAW'(tail_slot);
    q_wdata        = req_tid;
    q_re           = 1'b0;
    q_raddr        = qbase + QAW'(ent.head);

    case (state)
      flt_pkg::S_CLEAR: begin
        lk_we        = 1'b1;
        lk_waddr     = clr_idx;
        ent_wr       = '0;
        clr_idx_next = clr_idx + LW'(1);
        if (clr_idx == LW'(NUM_LOCKS - 1)) begin
          state_next = flt_pkg::S_IDLE;
        end
      end

      flt_pkg::S_IDLE: begin
        if (start) begin
          lk_re      = 1'b1;
          state_next = flt_pkg::S_LOOK;
        end
      end

      flt_pkg::S_LOOK: begin
        state_next = flt_pkg::S_IDLE;
        done_next  = 1'b1;
        res_next   = '{status: flt_pkg::ST_REFUSED, next_owner: '0, next_owner_valid: 1'b0};
        if (!req_bad) begin
          case (req_cmd)
            flt_pkg::CMD_LOCK: begin
              if (!ent.held) begin
                lk_we           = 1'b1;
                ent_wr.held     = 1'b1;
                ent_wr.owner    = req_tid;
                res_next.status = flt_pkg::ST_GRANTED;
              end else if (ent.count == CNT_W'(NUM_THREADS)) begin
                res_next.status = flt_pkg::ST_QUEUE_FULL;
              end else begin
                q_we            = 1'b1;
                lk_we           = 1'b1;
                ent_wr.count    = ent.count + CNT_W'(1);
                res_next.status = flt_pkg::ST_QUEUED;
              end
            end
            flt_pkg::CMD_TRY: begin
              if (!ent.held) begin
                lk_we           = 1'b1;
                ent_wr.held     = 1'b1;
                ent_wr.owner    = req_tid;
                res_next.status = flt_pkg::ST_GRANTED;
              end else if (ent.owner == req_tid) begin
                res_next.status = flt_pkg::ST_GRANTED;
              end
            end
            flt_pkg::CMD_UNLOCK: begin
              if (!ent.held || ent.owner != req_tid) begin
                res_next.status = flt_pkg::ST_NOT_OWNER;
              end else if (ent.count == '0) begin
                lk_we           = 1'b1;
                ent_wr.held     = 1'b0;
                ent_wr.owner    = '0;
                res_next.status = flt_pkg::ST_FREED;
              end else begin
                // Fetch the oldest waiter; the entry is written back once it arrives.
                q_re           = 1'b1;
                pop_head_next  = (head_inc == CNT_W'(NUM_THREADS)) ? '0 : TW'(head_inc);
                pop_count_next = ent.count - CNT_W'(1);
                done_next      = 1'b0;
                state_next     = flt_pkg::S_POP;
              end
            end
            default: begin
              res_next.status = flt_pkg::ST_REFUSED;
            end
          endcase
        end
      end

      flt_pkg::S_POP: begin
        lk_we        = 1'b1;
        ent_wr.held  = 1'b1;
        ent_wr.owner = q_rdata;
        ent_wr.head  = pop_head;
        ent_wr.count = pop_count;
        res_next     = '{status: flt_pkg::ST_HANDED, next_owner: q_rdata,
                         next_owner_valid: 1'b1};
        done_next    = 1'b1;
        state_next   = flt_pkg::S_IDLE;
      end

      default: begin
        state_next = flt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/fifo_handoff_lock_table.sv =====
// Top level of the hardware lock table with FIFO hand-over to waiting threads.
// Sequence: an accepted request reads its lock entry, the outcome is decided in S_LOOK
// and the registered result is strobed on done; when an unlock hands the lock to a
// waiter, the oldest waiter is read from the wait-queue memory and the entry is written
// back in S_POP first. A new request is taken only in idle, once the last is decided.
// Reset: synchronous rst starts a clearing pass over every lock entry, with busy high;
// the receiver of results cannot stall, so done is a single-cycle strobe.
`timescale 1ns / 1ps

module fifo_handoff_lock_table #(
  parameter int NUM_LOCKS   = flt_pkg::DEF_NUM_LOCKS,
  parameter int NUM_THREADS = flt_pkg::DEF_NUM_THREADS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [flt_pkg::CMD_W-1:0]     command,
  input  logic [flt_pkg::TID_W-1:0]     requester,
  input  logic [flt_pkg::LID_W-1:0]     lock_id,
  output logic                          done,
  output logic [flt_pkg::STATUS_W-1:0]  status,
  output logic [flt_pkg::TID_W-1:0]     next_owner,
  output logic                          next_owner_valid
);

  // Address widths of the two memories. Each lock entry holds the held flag, the owner,
  // the ring head and the waiter count; the wait queue is one ring of thread numbers
  // per lock, laid out lock by lock.
  localparam int LW    = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int TW    = $clog2(NUM_THREADS);
  localparam int QAW   = $clog2(NUM_LOCKS * NUM_THREADS);
  localparam int ENT_W = 2 + flt_pkg::TID_W + 2 * TW;

  logic                        lk_we, lk_re;
  logic [LW-1:0]               lk_waddr, lk_raddr;
  logic [ENT_W-1:0]            lk_wdata, lk_rdata;
  logic                        q_we, q_re;
  logic [QAW-1:0]              q_waddr, q_raddr;
  logic [flt_pkg::TID_W-1:0]   q_wdata, q_rdata;
  flt_pkg::result_t            res;

  // The sequencer owns all decisions: it reads a lock entry, decides the outcome of the
  // request and writes the entry back before the next request is taken, so no two
  // accesses to the same entry ever overlap.
  flt_ctrl #(
    .NUM_LOCKS   (NUM_LOCKS),
    .NUM_THREADS (NUM_THREADS),
    .LW          (LW),
    .TW          (TW),
    .QAW         (QAW),
    .ENT_W       (ENT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .command   (command),
    .requester (requester),
    .lock_id   (lock_id),
    .busy      (busy),
    .res       (res),
    .done      (done),
    .lk_we     (lk_we),
    .lk_waddr  (lk_waddr),
    .lk_wdata  (lk_wdata),
    .lk_re     (lk_re),
    .lk_raddr  (lk_raddr),
    .lk_rdata  (lk_rdata),
    .q_we      (q_we),
    .q_waddr   (q_waddr),
    .q_wdata   (q_wdata),
    .q_re      (q_re),
    .q_raddr   (q_raddr),
    .q_rdata   (q_rdata)
  );

  // Lock entry memory, cleared by the pass after reset.
  flt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_LOCKS),
    .AW    (LW)
  ) u_lock_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (lk_re),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  // Wait-queue memory. Only slots that a queued request has written are ever read,
  // so it needs no clearing.
  flt_ram #(
    .WIDTH (flt_pkg::TID_W),
    .DEPTH (NUM_LOCKS * NUM_THREADS),
    .AW    (QAW)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  assign status           = res.status;
  assign next_owner       = res.next_owner;
  assign next_owner_valid = res.next_owner_valid;

  // A result is only ever presented once the sequencer has returned to idle.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a request is still in progress");

  // An accepted request always occupies the sequencer in the following cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  // Each result is strobed only after the sequencer has been busy with its request.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result strobe without a request being processed");

  // A resumed thread is reported only together with a hand-over.
  assert property (@(posedge clk) disable iff (rst)
                   (done && next_owner_valid) |-> (status == flt_pkg::ST_HANDED))
    else $error("next owner reported without a hand-over");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the FIFO hand-off lock table: directed and random requests.
`timescale 1ns / 1ps

module testbench;

  localparam int LOCKS    = flt_pkg::DEF_NUM_LOCKS;
  localparam int THREADS  = flt_pkg::DEF_NUM_THREADS;
  localparam int CMD_W    = flt_pkg::CMD_W;
  localparam int TID_W    = flt_pkg::TID_W;
  localparam int LID_W    = flt_pkg::LID_W;
  localparam int STATUS_W = flt_pkg::STATUS_W;

  // Command code 3 is not a member of cmd_t. The block must refuse it.
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  // The lock table has no result FIFO downstream. SETTLE_CYCLES of extra waiting at the end
  // leave room for a straggling strobe to appear.
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 1000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [CMD_W-1:0]     command = '0;
  logic [TID_W-1:0]     requester = '0;
  logic [LID_W-1:0]     lock_id = '0;
  logic                 done;
  logic [STATUS_W-1:0]  status;
  logic [TID_W-1:0]     next_owner;
  logic                 next_owner_valid;

  // Shadow copy of the lock table. It is updated as each request is accepted, so
  // the outcome of every request is known before the block reports it.
  logic                 lock_taken [LOCKS];
  logic [TID_W-1:0]     lock_holder [LOCKS];
  logic [TID_W-1:0]     waiter_ring [LOCKS][THREADS];
  logic [TID_W-1:0]     ring_head [LOCKS];
  logic [TID_W:0]       ring_count [LOCKS];

  // Outcomes of accepted requests, oldest first. Requests are handled one at a time,
  // so results come back in the order in which the requests went in.
  flt_pkg::result_t     pending_outcomes [$];
  int                   mismatch_count = 0;
  logic                 sender_idles = 1'b1;

  fifo_handoff_lock_table dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .command          (command),
    .requester        (requester),
    .lock_id          (lock_id),
    .done             (done),
    .status           (status),
    .next_owner       (next_owner),
    .next_owner_valid (next_owner_valid)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Works out the result of one request and applies its effect to the shadow table.
  // Waiters sit in a ring per lock; the slot for a newcomer is head plus count, which
  // wraps naturally in the four-bit index.
  function automatic flt_pkg::result_t resolve_request(input logic [CMD_W-1:0] cmd,
                                                       input logic [TID_W-1:0] tid,
                                                       input logic [LID_W-1:0] lid);
    flt_pkg::result_t outcome;
    logic [TID_W-1:0] slot;
    outcome.status           = flt_pkg::ST_REFUSED;
    outcome.next_owner       = '0;
    outcome.next_owner_valid = 1'b0;
    case (cmd)
      flt_pkg::CMD_LOCK: begin
        if (!lock_taken[lid]) begin
          lock_taken[lid]  = 1'b1;
          lock_holder[lid] = tid;
          outcome.status   = flt_pkg::ST_GRANTED;
        end else if (ring_count[lid] == THREADS) begin
          outcome.status = flt_pkg::ST_QUEUE_FULL;
        end else begin
          // The owner itself is queued too, and will later be handed its own lock.
          slot                   = ring_head[lid] + ring_count[lid][TID_W-1:0];
          waiter_ring[lid][slot] = tid;
          ring_count[lid]        = ring_count[lid] + 1'b1;
          outcome.status         = flt_pkg::ST_QUEUED;
        end
      end
      flt_pkg::CMD_TRY: begin
        if (!lock_taken[lid]) begin
          lock_taken[lid]  = 1'b1;
          lock_holder[lid] = tid;
          outcome.status   = flt_pkg::ST_GRANTED;
        end else if (lock_holder[lid] == tid) begin
          outcome.status = flt_pkg::ST_GRANTED;
        end else begin
          outcome.status = flt_pkg::ST_REFUSED;
        end
      end
      flt_pkg::CMD_UNLOCK: begin
        if (!lock_taken[lid] || lock_holder[lid] != tid) begin
          outcome.status = flt_pkg::ST_NOT_OWNER;
        end else if (ring_count[lid] == 0) begin
          lock_taken[lid]  = 1'b0;
          lock_holder[lid] = '0;
          outcome.status   = flt_pkg::ST_FREED;
        end else begin
          // The oldest waiter becomes the owner and is reported for resuming.
          outcome.status           = flt_pkg::ST_HANDED;
          outcome.next_owner       = waiter_ring[lid][ring_head[lid]];
          outcome.next_owner_valid = 1'b1;
          lock_holder[lid]         = waiter_ring[lid][ring_head[lid]];
          ring_head[lid]           = ring_head[lid] + 1'b1;
          ring_count[lid]          = ring_count[lid] - 1'b1;
        end
      end
      default: begin
        outcome.status = flt_pkg::ST_REFUSED;
      end
    endcase
    return outcome;
  endfunction

  // Presents one request and holds it until the block takes it. It is called at a rising
  // edge and returns at the edge that accepted the request. The start line is left high,
  // so back-to-back requests go in without a gap unless an idle burst is drawn.
  task automatic send_request(input logic [CMD_W-1:0] cmd,
                              input logic [TID_W-1:0] tid,
                              input logic [LID_W-1:0] lid);
    int               gap;
    flt_pkg::result_t outcome;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    command   <= cmd;
    requester <= tid;
    lock_id   <= lid;
    do @(posedge clk); while (busy);
    outcome          = resolve_request(cmd, tid, lid);
    pending_outcomes = {pending_outcomes, outcome};
  endtask

  // Every strobed result is checked against the oldest outstanding outcome.
  always @(posedge clk) begin
    flt_pkg::result_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        $error("result strobed with no request outstanding: status %0d", status);
        mismatch_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatch_count++;
        end
        if (next_owner !== want.next_owner) begin
          $error("next_owner: expected %0d, got %0d", want.next_owner, next_owner);
          mismatch_count++;
        end
        if (next_owner_valid !== want.next_owner_valid) begin
          $error("next_owner_valid: expected %0d, got %0d",
                 want.next_owner_valid, next_owner_valid);
          mismatch_count++;
        end
      end
    end
  end

  // Ownership rules on a single lock: try-lock by the owner and by a stranger, the owner
  // queuing on itself, unlock by a non-owner, hand-over in arrival order, release of the
  // lock, unlock of a free lock, and a command code that does not exist.
  task automatic test_ownership_rules();
    send_request(flt_pkg::CMD_LOCK,   4'd0,  6'd0);
    send_request(flt_pkg::CMD_TRY,    4'd0,  6'd0);
    send_request(flt_pkg::CMD_TRY,    4'd15, 6'd0);
    send_request(flt_pkg::CMD_LOCK,   4'd0,  6'd0);
    send_request(flt_pkg::CMD_LOCK,   4'd15, 6'd0);
    send_request(flt_pkg::CMD_UNLOCK, 4'd15, 6'd0);
    send_request(flt_pkg::CMD_UNLOCK, 4'd0,  6'd0);
    send_request(flt_pkg::CMD_UNLOCK, 4'd0,  6'd0);
    send_request(flt_pkg::CMD_UNLOCK, 4'd15, 6'd0);
    send_request(flt_pkg::CMD_UNLOCK, 4'd15, 6'd0);
    send_request(CMD_UNKNOWN,         4'd15, 6'd63);
  endtask

  // The highest lock is taken by a try-lock, then every thread queues on it until the
  // queue is full and one more blocking request is turned away. The queue is left full;
  // the random traffic drains it later.
  task automatic test_queue_overflow();
    int t;
    send_request(flt_pkg::CMD_TRY, 4'd15, 6'd63);
    for (t = 0; t < THREADS; t++) begin
      send_request(flt_pkg::CMD_LOCK, TID_W'(t), 6'd63);
    end
    send_request(flt_pkg::CMD_LOCK, 4'd7, 6'd63);
  endtask

  // Random traffic. Most requests go to a handful of busy locks so that queues build up,
  // wrap round and empty again; most unlocks come from the real owner so that hand-overs
  // are common. The rest is noise: stray unlocks, unknown commands and other locks.
  // Idle bursts stop for the last quarter so that requests also run back to back.
  task automatic test_random_traffic(input int n_requests);
    int                 i;
    int                 roll;
    logic [LID_W-1:0]   busy_locks [4];
    logic [CMD_W-1:0]   cmd;
    logic [TID_W-1:0]   tid;
    logic [LID_W-1:0]   lid;
    for (i = 0; i < 4; i++) begin
      busy_locks[i] = LID_W'($urandom_range(0, LOCKS - 1));
    end
    busy_locks[3] = 6'd63;
    for (i = 0; i < n_requests; i++) begin
      sender_idles = (i < (n_requests * 3) / 4);
      if ($urandom_range(0, 9) < 8) begin
        lid = busy_locks[$urandom_range(0, 3)];
      end else begin
        lid = LID_W'($urandom_range(0, LOCKS - 1));
      end
      tid  = TID_W'($urandom_range(0, THREADS - 1));
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        cmd = flt_pkg::CMD_LOCK;
      end else if (roll < 55) begin
        cmd = flt_pkg::CMD_TRY;
      end else if (roll < 93) begin
        cmd = flt_pkg::CMD_UNLOCK;
        if (lock_taken[lid]) begin
          tid = lock_holder[lid];
        end
      end else if (roll < 97) begin
        cmd = flt_pkg::CMD_UNLOCK;
      end else begin
        cmd = CMD_UNKNOWN;
      end
      send_request(cmd, tid, lid);
    end
  endtask

  initial begin
    int drain_cycles;
    for (int l = 0; l < LOCKS; l++) begin
      lock_taken[l]  = 1'b0;
      lock_holder[l] = '0;
      ring_head[l]   = '0;
      ring_count[l]  = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // The block clears its lock memory after reset with busy high; the first request
    // simply waits for that to finish.
    test_ownership_rules();
    test_queue_overflow();
    test_random_traffic(1270);
    start <= 1'b0;
    drain_cycles = 0;
    while (pending_outcomes.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      $error("%0d results never arrived", pending_outcomes.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS fifo_handoff_lock_table");
    end else begin
      $display("FAIL fifo_handoff_lock_table");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this time.
  initial begin
    #1000000;
    $display("FAIL fifo_handoff_lock_table");
    $finish;
  end

endmodule
